// ----- design/spss_pkg.sv -----
// ----------------------------------------------------------------------------
// Station phase shift sin/cos: shared package
// Widths, register indexes, sideband type and series constants used by the
// phase pipeline, the sin/cos pipeline and the top level.
// ----------------------------------------------------------------------------
package spss_pkg;

    // Default values of the top-level parameters.
    localparam int ANGLE_BITS_DEF = 24;
    localparam int OUT_BITS_DEF   = 18;

    // Fixed field widths.
    localparam int COORD_W    = 32;
    localparam int TAG_W      = 8;
    localparam int TPM_W      = 48;
    localparam int RATIO_W    = 32;
    localparam int IN_TDATA_W = 6 * COORD_W;

    // Configuration port.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_ADDR_W-1:0] CFG_TURNS_PER_MM = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_RATIO   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_ENABLE  = 2'd2;

    // Quadrant codes of the angle.
    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;
    localparam logic [1:0] QUAD_IV  = 2'd3;

    // Pi in Q32 and one in Q30.
    localparam logic [33:0] PI_Q32 = 34'h3243F6A88;
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    // Taylor series: seven terms after the first, with the divisor of each
    // term and the base-two logarithm of that divisor, rounded up.
    localparam int SC_ROUNDS = 7;
    localparam int unsigned SIN_DIV [SC_ROUNDS] = '{6, 20, 42, 72, 110, 156, 210};
    localparam int unsigned SIN_SH  [SC_ROUNDS] = '{3, 5, 6, 7, 7, 8, 8};
    localparam int unsigned COS_DIV [SC_ROUNDS] = '{2, 12, 30, 56, 90, 132, 182};
    localparam int unsigned COS_SH  [SC_ROUNDS] = '{1, 4, 5, 6, 7, 8, 8};

    // Pipeline depths.
    localparam int PH_LAT = 8;
    localparam int SC_LAT = 2 + 3 * SC_ROUNDS + 2;

    // Control that travels beside each item.
    typedef struct packed {
        logic             valid;
        logic             step;
        logic [TAG_W-1:0] tag;
    } t_side;

endpackage

// ----- design/spss_phase.sv -----
// ----------------------------------------------------------------------------
// Station phase shift sin/cos: phase pipeline
// Eight stages forming the delay u*l + v*m + w*(n-1), the base phase in turns
// and the step phase, and slicing both fractional-turn angles.
// ----------------------------------------------------------------------------
module spss_phase #(
    parameter int ANGLE_BITS = spss_pkg::ANGLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  spss_pkg::t_side                     i_side,
    input  logic signed [spss_pkg::COORD_W-1:0] i_u_mm,
    input  logic signed [spss_pkg::COORD_W-1:0] i_v_mm,
    input  logic signed [spss_pkg::COORD_W-1:0] i_w_mm,
    input  logic signed [spss_pkg::COORD_W-1:0] i_l_cos,
    input  logic signed [spss_pkg::COORD_W-1:0] i_m_cos,
    input  logic signed [spss_pkg::COORD_W-1:0] i_n_cos,
    input  logic        [spss_pkg::TPM_W-1:0]   i_turns_per_mm,
    input  logic        [spss_pkg::RATIO_W-1:0] i_step_ratio,
    output spss_pkg::t_side                     o_side,
    output logic        [ANGLE_BITS-1:0]        o_angle_base,
    output logic        [ANGLE_BITS-1:0]        o_angle_step
);
    import spss_pkg::*;

    // Stage 1: the three coordinate products.
    logic signed [32:0]  n_nm1;
    logic signed [63:0]  r_ul;
    logic signed [63:0]  r_vm;
    logic signed [64:0]  r_wn;

    assign n_nm1 = {i_n_cos[31], i_n_cos} - 33'sh0_4000_0000;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ul <= i_u_mm * i_l_cos;
            r_vm <= i_v_mm * i_m_cos;
            r_wn <= i_w_mm * n_nm1;
        end
    end

    // Stage 2: the exact delay in Q.30 millimetres.
    logic signed [66:0] r_dot;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dot <= 67'(r_ul) + 67'(r_vm) + 67'(r_wn);
        end
    end

    // Stage 3: partial products of the delay and the turns per millimetre.
    logic        [55:0] r_p00;
    logic        [55:0] r_p01;
    logic        [55:0] r_p10;
    logic        [55:0] r_p11;
    logic signed [51:0] r_p2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00 <= 56'(r_dot[31:0]) * 56'(i_turns_per_mm[23:0]);
            r_p01 <= 56'(r_dot[31:0]) * 56'(i_turns_per_mm[47:24]);
            r_p10 <= 56'(r_dot[63:32]) * 56'(i_turns_per_mm[23:0]);
            r_p11 <= 56'(r_dot[63:32]) * 56'(i_turns_per_mm[47:24]);
            r_p2  <= $signed(r_dot[66:64]) * $signed({1'b0, i_turns_per_mm});
        end
    end

    // Stage 4: two partial sums of the phase.
    logic [89:0]  r_a;
    logic [109:0] r_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= 90'(r_p00) + (90'(r_p01) << 24) + (90'(r_p10) << 32);
            r_b <= (110'(r_p11) << 56) + (110'(r_p2) << 64);
        end
    end

    // Stage 5: the phase in Q.78 turns, kept to the bits the step needs.
    logic [109:0] r_ph;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ph <= 110'(r_a) + r_b;
        end
    end

    // Stage 6: partial products of the phase and the step ratio.
    logic [63:0]           r_pp0;
    logic [63:0]           r_pp1;
    logic [63:0]           r_pp2;
    logic [45:0]           r_pp3;
    logic [ANGLE_BITS-1:0] r_base6;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp0   <= 64'(r_ph[31:0]) * 64'(i_step_ratio);
            r_pp1   <= 64'(r_ph[63:32]) * 64'(i_step_ratio);
            r_pp2   <= 64'(r_ph[95:64]) * 64'(i_step_ratio);
            r_pp3   <= 46'(r_ph[109:96]) * 46'(i_step_ratio);
            r_base6 <= r_ph[78-ANGLE_BITS +: ANGLE_BITS];
        end
    end

    // Stage 7: two partial sums of the step phase.
    logic [95:0]           r_sa;
    logic [109:0]          r_sb;
    logic [ANGLE_BITS-1:0] r_base7;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sa    <= 96'(r_pp0) + (96'(r_pp1) << 32);
            r_sb    <= (110'(r_pp2) << 64) + (110'(r_pp3) << 96);
            r_base7 <= r_base6;
        end
    end

    // Stage 8: the step phase in Q.110 turns and both angles.
    logic [109:0] n_pst;

    assign n_pst = 110'(r_sa) + r_sb;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_angle_step <= n_pst[110-ANGLE_BITS +: ANGLE_BITS];
            o_angle_base <= r_base7;
        end
    end

    // Sideband delay line matching the eight stages.
    t_side r_side [PH_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PH_LAT; i++) begin
                r_side[i].valid <= 1'b0;
            end
        end else if (i_en) begin
            r_side[0] <= i_side;
            for (int i = 1; i < PH_LAT; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    assign o_side = r_side[PH_LAT-1];

endmodule

// ----- design/spss_sincos.sv -----
// ----------------------------------------------------------------------------
// Station phase shift sin/cos: sine and cosine pipeline
// Turns an angle in turns into cosine and sine by a Q30 Taylor series, one
// series term per three stages, then rounds and folds into the quadrant.
// ----------------------------------------------------------------------------
module spss_sincos #(
    parameter int ANGLE_BITS = spss_pkg::ANGLE_BITS_DEF,
    parameter int OUT_BITS   = spss_pkg::OUT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [ANGLE_BITS-1:0] i_angle,
    output logic [OUT_BITS-1:0]   o_cos,
    output logic [OUT_BITS-1:0]   o_sin
);
    import spss_pkg::*;

    localparam int RB = ANGLE_BITS - 2;
    localparam int SH = 32 - OUT_BITS;
    localparam logic [33:0] HALF = 34'd1 << (SH - 1);

    // Round a Q30 value to the output fraction, half away from zero.
    function automatic logic [OUT_BITS-1:0] round_out(input logic signed [32:0] v);
        logic signed [33:0] vx;
        logic [33:0]        mag;
        logic [33:0]        r;
        vx  = 34'(v);
        mag = (vx < 0) ? 34'(-vx) : 34'(vx);
        r   = (mag + HALF) >> SH;
        return v[32] ? OUT_BITS'(-r) : OUT_BITS'(r);
    endfunction

    // Stage 0: remainder to radians in Q30.
    logic [RB+33:0] n_xprod;
    logic [30:0]    r0_x;
    logic [1:0]     r0_q;

    assign n_xprod = (RB+34)'(i_angle[RB-1:0]) * (RB+34)'(PI_Q32);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_x <= n_xprod[RB+3 +: 31];
            r0_q <= i_angle[ANGLE_BITS-1 -: 2];
        end
    end

    // Stage 1: square of the angle and the starting terms.
    logic [61:0]        n_sq;
    logic [31:0]        r_ts [SC_ROUNDS];
    logic [31:0]        r_tc [SC_ROUNDS];
    logic [31:0]        r_x2 [SC_ROUNDS];
    logic signed [32:0] r_ss [SC_ROUNDS+1];
    logic signed [32:0] r_sc [SC_ROUNDS+1];
    logic [1:0]         r_q  [SC_ROUNDS+1];

    assign n_sq = 62'(r0_x) * 62'(r0_x);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ts[0] <= 32'(r0_x);
            r_tc[0] <= ONE_Q30;
            r_x2[0] <= n_sq[61:30];
            r_ss[0] <= $signed({2'b00, r0_x});
            r_sc[0] <= $signed({1'b0, ONE_Q30});
            r_q[0]  <= r0_q;
        end
    end

    // One series term per round: multiply, divide by reciprocal, accumulate.
    for (genvar g = 1; g <= SC_ROUNDS; g++) begin : g_round
        localparam int unsigned DS = SIN_DIV[g-1];
        localparam int unsigned SS = SIN_SH[g-1];
        localparam int unsigned DC = COS_DIV[g-1];
        localparam int unsigned SC = COS_SH[g-1];
        localparam logic [32:0] MS = 33'(((64'd1 << (32 + SS)) + DS - 1) / DS);
        localparam logic [32:0] MC = 33'(((64'd1 << (32 + SC)) + DC - 1) / DC);
        localparam bit ODD = (g % 2) == 1;

        logic [63:0]        r_ps;
        logic [63:0]        r_pc;
        logic signed [32:0] r_a_ss;
        logic signed [32:0] r_a_sc;
        logic [1:0]         r_a_q;
        logic [64:0]        r_ms;
        logic [64:0]        r_mc;
        logic signed [32:0] r_b_ss;
        logic signed [32:0] r_b_sc;
        logic [1:0]         r_b_q;
        logic [31:0]        n_ts;
        logic [31:0]        n_tc;

        // Term times the squared angle.
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ps   <= 64'(r_ts[g-1]) * 64'(r_x2[g-1]);
                r_pc   <= 64'(r_tc[g-1]) * 64'(r_x2[g-1]);
                r_a_ss <= r_ss[g-1];
                r_a_sc <= r_sc[g-1];
                r_a_q  <= r_q[g-1];
            end
        end

        // Exact division by the term divisor through its reciprocal.
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ms   <= 65'(r_ps[61:30]) * 65'(MS);
                r_mc   <= 65'(r_pc[61:30]) * 65'(MC);
                r_b_ss <= r_a_ss;
                r_b_sc <= r_a_sc;
                r_b_q  <= r_a_q;
            end
        end

        assign n_ts = 32'(r_ms >> (32 + SS));
        assign n_tc = 32'(r_mc >> (32 + SC));

        // Alternating accumulation of the new terms.
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (ODD) begin
                    r_ss[g] <= r_b_ss - $signed({1'b0, n_ts});
                    r_sc[g] <= r_b_sc - $signed({1'b0, n_tc});
                end else begin
                    r_ss[g] <= r_b_ss + $signed({1'b0, n_ts});
                    r_sc[g] <= r_b_sc + $signed({1'b0, n_tc});
                end
                r_q[g] <= r_b_q;
            end
        end

        // Terms and squared angle go on to the next round.
        if (g < SC_ROUNDS) begin : g_next
            logic [31:0] r_a_x2;
            logic [31:0] r_b_x2;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_a_x2  <= r_x2[g-1];
                    r_b_x2  <= r_a_x2;
                    r_x2[g] <= r_b_x2;
                    r_ts[g] <= n_ts;
                    r_tc[g] <= n_tc;
                end
            end
        end
    end

    // Rounding to the output format.
    logic [OUT_BITS-1:0] r_rs;
    logic [OUT_BITS-1:0] r_rc;
    logic [1:0]          r_rq;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rs <= round_out(r_ss[SC_ROUNDS]);
            r_rc <= round_out(r_sc[SC_ROUNDS]);
            r_rq <= r_q[SC_ROUNDS];
        end
    end

    // Quadrant folding by swap and negation.
    logic [OUT_BITS-1:0] n_cos;
    logic [OUT_BITS-1:0] n_sin;

    always_comb begin
        case (r_rq)
            QUAD_I: begin
                n_cos = r_rc;
                n_sin = r_rs;
            end
            QUAD_II: begin
                n_cos = -r_rs;
                n_sin = r_rc;
            end
            QUAD_III: begin
                n_cos = -r_rc;
                n_sin = -r_rs;
            end
            default: begin
                n_cos = r_rs;
                n_sin = -r_rc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= n_cos;
            o_sin <= n_sin;
        end
    end

endmodule

// ----- design/station_phase_shift_sincos.sv -----
// ----------------------------------------------------------------------------
// Station phase shift sin/cos: top level
// Per item, the geometric phase of one station towards one direction, and its
// cosine and sine, for the base frequency and optionally the channel step.
//
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata u,v,w,l,m,n; tuser tag
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata cos/sin base/step;
//                                                    tuser tag, step_valid
// cfg       in         i_cfg_we                      i_cfg_addr, i_cfg_wdata
//
// An item is taken per cycle while the skid register is empty. A result passes
// the 8-stage phase pipeline, the 25-stage sin/cos series and the output register.
// Reset clears the configuration registers and all valid bits.
// A stalled output is caught in a one-entry skid register; the pipeline then
// holds as a whole until the skid register drains.
// ----------------------------------------------------------------------------
module station_phase_shift_sincos #(
    parameter int ANGLE_BITS = spss_pkg::ANGLE_BITS_DEF,
    parameter int OUT_BITS   = spss_pkg::OUT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Fields from bit 0: u_mm, v_mm, w_mm, l_cos, m_cos, n_cos.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [spss_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // Fields from bit 0: eval_tag.
    input  logic [spss_pkg::TAG_W-1:0]          s_axis_tuser,
    // Fields from bit 0: cos_base, sin_base, cos_step, sin_step, zero fill.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [((4*OUT_BITS+7)/8)*8-1:0]     m_axis_tdata,
    // Fields from bit 0: out_tag, step_valid.
    output logic [spss_pkg::TAG_W:0]            m_axis_tuser,
    input  logic                                i_cfg_we,
    input  logic [spss_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [spss_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import spss_pkg::*;

    localparam int OUT_TDATA_W = ((4 * OUT_BITS + 7) / 8) * 8;
    localparam int RES_W       = 4 * OUT_BITS;

    // Configuration registers.
    logic [TPM_W-1:0]   r_turns_per_mm;
    logic [RATIO_W-1:0] r_step_ratio;
    logic               r_step_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turns_per_mm <= '0;
            r_step_ratio   <= '0;
            r_step_enable  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_TURNS_PER_MM: r_turns_per_mm <= i_cfg_wdata[TPM_W-1:0];
                CFG_STEP_RATIO:   r_step_ratio   <= i_cfg_wdata[RATIO_W-1:0];
                CFG_STEP_ENABLE:  r_step_enable  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // The whole pipeline advances unless the skid register is occupied.
    logic r_skd_vld;
    logic w_en;

    assign w_en          = !r_skd_vld;
    assign s_axis_tready = w_en;

    // Input sideband.
    t_side w_in_side;

    always_comb begin
        w_in_side.valid = s_axis_tvalid;
        w_in_side.step  = r_step_enable;
        w_in_side.tag   = s_axis_tuser;
    end

    // Phase pipeline.
    t_side                 w_ph_side;
    logic [ANGLE_BITS-1:0] w_angle_base;
    logic [ANGLE_BITS-1:0] w_angle_step;

    spss_phase #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_phase (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_side         (w_in_side),
        .i_u_mm         ($signed(s_axis_tdata[0*COORD_W +: COORD_W])),
        .i_v_mm         ($signed(s_axis_tdata[1*COORD_W +: COORD_W])),
        .i_w_mm         ($signed(s_axis_tdata[2*COORD_W +: COORD_W])),
        .i_l_cos        ($signed(s_axis_tdata[3*COORD_W +: COORD_W])),
        .i_m_cos        ($signed(s_axis_tdata[4*COORD_W +: COORD_W])),
        .i_n_cos        ($signed(s_axis_tdata[5*COORD_W +: COORD_W])),
        .i_turns_per_mm (r_turns_per_mm),
        .i_step_ratio   (r_step_ratio),
        .o_side         (w_ph_side),
        .o_angle_base   (w_angle_base),
        .o_angle_step   (w_angle_step)
    );

    // Cosine and sine of both angles.
    logic [OUT_BITS-1:0] w_cos_base;
    logic [OUT_BITS-1:0] w_sin_base;
    logic [OUT_BITS-1:0] w_cos_step;
    logic [OUT_BITS-1:0] w_sin_step;

    spss_sincos #(
        .ANGLE_BITS (ANGLE_BITS),
        .OUT_BITS   (OUT_BITS)
    ) u_sincos_base (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (w_angle_base),
        .o_cos   (w_cos_base),
        .o_sin   (w_sin_base)
    );

    spss_sincos #(
        .ANGLE_BITS (ANGLE_BITS),
        .OUT_BITS   (OUT_BITS)
    ) u_sincos_step (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (w_angle_step),
        .o_cos   (w_cos_step),
        .o_sin   (w_sin_step)
    );

    // Sideband delay line matching the sin/cos pipelines.
    t_side r_dly [SC_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SC_LAT; i++) begin
                r_dly[i].valid <= 1'b0;
            end
        end else if (w_en) begin
            r_dly[0] <= w_ph_side;
            for (int i = 1; i < SC_LAT; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    // Result of the pipeline tail; step fields are zero when step is off.
    t_side               w_tail;
    logic [RES_W-1:0]    w_res;
    logic [TAG_W:0]      w_user;

    assign w_tail = r_dly[SC_LAT-1];

    always_comb begin
        if (w_tail.step) begin
            w_res = {w_sin_step, w_cos_step, w_sin_base, w_cos_base};
        end else begin
            w_res = {{(2*OUT_BITS){1'b0}}, w_sin_base, w_cos_base};
        end
        w_user = {w_tail.step, w_tail.tag};
    end

    // Output register and skid register.
    logic               r_out_vld;
    logic [RES_W-1:0]   r_out_data;
    logic [TAG_W:0]     r_out_user;
    logic [RES_W-1:0]   r_skd_data;
    logic [TAG_W:0]     r_skd_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else if (r_out_vld && !m_axis_tready) begin
            // Output held: a leaving item parks in the skid register.
            if (w_en && w_tail.valid) begin
                r_skd_vld  <= 1'b1;
                r_skd_data <= w_res;
                r_skd_user <= w_user;
            end
        end else if (r_skd_vld) begin
            // Output free: the parked item goes first.
            r_out_vld  <= 1'b1;
            r_out_data <= r_skd_data;
            r_out_user <= r_skd_user;
            r_skd_vld  <= 1'b0;
        end else begin
            r_out_vld  <= w_tail.valid;
            r_out_data <= w_res;
            r_out_user <= w_user;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_data);
    assign m_axis_tuser  = r_out_user;

endmodule

// ----- tb/sv/station_phase_shift_sincos_tb.sv -----
// ----------------------------------------------------------------------------
// Station phase shift sin/cos: testbench
// Drives station positions and direction cosines into the stream input and
// compares every output transfer with a bit-exact software predictor of the
// phase, the truncated turn and the series sine and cosine. The registers
// are rewritten between phases, and both sides of the stream stall at random.
// ----------------------------------------------------------------------------
module station_phase_shift_sincos_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import spss_pkg::*;

    localparam int ABITS = ANGLE_BITS_DEF;
    localparam int OBITS = OUT_BITS_DEF;
    localparam int OUT_TDATA_W = ((4 * OBITS + 7) / 8) * 8;
    // Index past the end of the register list; writes to it must be dropped.
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [TPM_W-1:0] TPM_MAX = '1;
    localparam logic [RATIO_W-1:0] RATIO_MAX = '1;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_COUNT = 6;
    localparam int PHASE_ITEMS = 125;

    // One result as the block presents it.
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [OBITS-1:0] cos_base;
        logic [OBITS-1:0] sin_base;
        logic [OBITS-1:0] cos_step;
        logic [OBITS-1:0] sin_step;
        logic             step_valid;
    } t_phasor;

    // Directed stimulus row.
    typedef struct {
        logic [IN_TDATA_W-1:0] coords;
        logic [TAG_W-1:0]      tag;
        bit                    fixed;
        t_phasor               want;
    } t_row;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [IN_TDATA_W-1:0]       s_axis_tdata = '0;
    logic [TAG_W-1:0]            s_axis_tuser = '0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]      m_axis_tdata;
    logic [TAG_W:0]              m_axis_tuser;
    logic                        i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]       i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]       i_cfg_wdata = '0;

    // Predictor copy of the registers.
    logic [TPM_W-1:0]   turns_per_mm = '0;
    logic [RATIO_W-1:0] step_ratio = '0;
    logic               step_enable = 1'b0;

    // Row marker that travels with the item on the input bus.
    bit      cur_fixed = 1'b0;
    t_phasor cur_want = '0;

    t_phasor phasor_fifo[$];
    int      mismatches = 0;
    int      results_seen = 0;
    int      items_sent = 0;
    int      sender_idle_pct = 0;
    int      receiver_idle_pct = 0;

    station_phase_shift_sincos u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Q30 series value rounded half away from zero to the output fraction.
    function automatic logic signed [63:0] round_q30(input logic signed [63:0] s);
        logic signed [63:0] half;
        half = 64'sd1 <<< (30 - (OBITS - 2) - 1);
        if (s < 0) begin
            return -((-s + half) >>> (30 - (OBITS - 2)));
        end
        return (s + half) >>> (30 - (OBITS - 2));
    endfunction

    // Cosine and sine of an angle given in turns, by quadrant and series.
    function automatic void turn_sincos(input logic [ABITS-1:0] ang,
                                        output logic [OBITS-1:0] cs,
                                        output logic [OBITS-1:0] sn);
        logic [1:0]         quad;
        logic [63:0]        x, x2, ts, tc;
        logic signed [63:0] ss, sc, s, c, co, si;
        quad = ang[ABITS-1 -: 2];
        x = (64'(ang[ABITS-3:0]) * 64'(PI_Q32)) >> (ABITS - 2 + 3);
        x2 = (x * x) >> 30;
        ts = x;
        tc = 64'(ONE_Q30);
        ss = $signed(x);
        sc = $signed(64'(ONE_Q30));
        for (int k = 1; k <= SC_ROUNDS; k++) begin
            ts = ((ts * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            tc = ((tc * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) begin
                ss = ss - $signed(ts);
                sc = sc - $signed(tc);
            end else begin
                ss = ss + $signed(ts);
                sc = sc + $signed(tc);
            end
        end
        s = round_q30(ss);
        c = round_q30(sc);
        case (quad)
            QUAD_I: begin
                co = c; si = s;
            end
            QUAD_II: begin
                co = -s; si = c;
            end
            QUAD_III: begin
                co = -c; si = -s;
            end
            default: begin
                co = s; si = -c;
            end
        endcase
        cs = co[OBITS-1:0];
        sn = si[OBITS-1:0];
    endfunction

    // Expected phasor pair of one station and direction.
    function automatic t_phasor predict_phasor(input logic [IN_TDATA_W-1:0] d,
                                               input logic [TAG_W-1:0] tag);
        logic signed [127:0] u, v, w, l, m, n, dot;
        logic [127:0]        ph, pst;
        t_phasor             r;
        u = $signed(d[0*COORD_W +: COORD_W]);
        v = $signed(d[1*COORD_W +: COORD_W]);
        w = $signed(d[2*COORD_W +: COORD_W]);
        l = $signed(d[3*COORD_W +: COORD_W]);
        m = $signed(d[4*COORD_W +: COORD_W]);
        n = $signed(d[5*COORD_W +: COORD_W]);
        dot = u * l + v * m + w * (n - (128'sd1 <<< 30));
        ph = dot * 128'(turns_per_mm);
        r = '0;
        r.tag = tag;
        turn_sincos(ph[78 - ABITS +: ABITS], r.cos_base, r.sin_base);
        if (step_enable) begin
            pst = ph * 128'(step_ratio);
            turn_sincos(pst[110 - ABITS +: ABITS], r.cos_step, r.sin_step);
        end
        r.step_valid = step_enable;
        return r;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch on %s at result %0d: expected %h, got %h",
                         what, results_seen, want, got);
            end
        end
    endtask

    // Record accepted inputs and check every output transfer.
    always @(posedge i_clk) begin
        t_phasor got, want;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            phasor_fifo.push_back(cur_fixed ? cur_want
                                            : predict_phasor(s_axis_tdata, s_axis_tuser));
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.tag = m_axis_tuser[TAG_W-1:0];
            got.step_valid = m_axis_tuser[TAG_W];
            got.cos_base = m_axis_tdata[0*OBITS +: OBITS];
            got.sin_base = m_axis_tdata[1*OBITS +: OBITS];
            got.cos_step = m_axis_tdata[2*OBITS +: OBITS];
            got.sin_step = m_axis_tdata[3*OBITS +: OBITS];
            if (phasor_fifo.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d arrived with nothing expected", results_seen);
                end
            end else begin
                want = phasor_fifo.pop_front();
                check_field("out_tag", 32'(want.tag), 32'(got.tag));
                check_field("cos_base", 32'(want.cos_base), 32'(got.cos_base));
                check_field("sin_base", 32'(want.sin_base), 32'(got.sin_base));
                check_field("cos_step", 32'(want.cos_step), 32'(got.cos_step));
                check_field("sin_step", 32'(want.sin_step), 32'(got.sin_step));
                check_field("step_valid", 32'(want.step_valid), 32'(got.step_valid));
            end
            results_seen++;
        end
    end

    // Receiver back-pressure.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Register write, mirrored into the predictor with the same masking.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_addr = idx;
        i_cfg_wdata = val;
        case (idx)
            CFG_TURNS_PER_MM: turns_per_mm = val[TPM_W-1:0];
            CFG_STEP_RATIO:   step_ratio = val[RATIO_W-1:0];
            CFG_STEP_ENABLE:  step_enable = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // One input transfer, with random gaps before it.
    task automatic send_item(input logic [IN_TDATA_W-1:0] coords,
                             input logic [TAG_W-1:0] tag,
                             input bit fixed, input t_phasor want);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = coords;
        s_axis_tuser = tag;
        cur_fixed = fixed;
        cur_want = want;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        end_burst();
        while (phasor_fifo.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Field values weighted toward extremes and realistic magnitudes.
    function automatic logic [COORD_W-1:0] pick_coord(input bit is_dir);
        case ($urandom_range(3))
            0: return $urandom;
            1: case ($urandom_range(3))
                   0: return 32'h8000_0000;
                   1: return 32'h7FFF_FFFF;
                   2: return 32'h0000_0000;
                   default: return 32'hFFFF_FFFF;
               endcase
            default: begin
                if (is_dir) begin
                    return 32'($signed($urandom_range(2 ** 31 - 1)) - 32'sh4000_0000);
                end
                return 32'($signed($urandom_range(200_000_000)) - 32'sd100_000_000);
            end
        endcase
    endfunction

    function automatic logic [IN_TDATA_W-1:0] random_coords();
        logic [IN_TDATA_W-1:0] d;
        for (int f = 0; f < 6; f++) begin
            d[f*COORD_W +: COORD_W] = pick_coord(f >= 3);
        end
        return d;
    endfunction

    // Extremes of the unsigned registers, a realistic value, and noise.
    function automatic logic [CFG_DATA_W-1:0] pick_tpm();
        case ($urandom_range(3))
            0: return '0;
            1: return CFG_DATA_W'(TPM_MAX);
            2: return 48'd140_737_488 + 48'($urandom_range(1_000_000)) * 48'd1000;
            default: return {16'($urandom), 32'($urandom)};
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_ratio();
        case ($urandom_range(3))
            0: return '0;
            1: return CFG_DATA_W'(RATIO_MAX);
            2: return {16'($urandom), 32'($urandom)};
            default: return 48'($urandom_range(4_000_000));
        endcase
    endfunction

    t_row rows[$];

    initial begin
        t_row    row;
        t_phasor unit;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // After reset the phase is zero whatever the coordinates.
        unit = '0;
        unit.cos_base = OBITS'(1 << (OBITS - 2));
        row.fixed = 1'b1;
        row.coords = '0;
        row.tag = 8'h00;
        row.want = unit;
        rows.push_back(row);
        row.coords = '1;
        row.tag = 8'hFF;
        row.want = unit;
        row.want.tag = 8'hFF;
        rows.push_back(row);
        row.coords = {6{32'h8000_0000}};
        row.tag = 8'h5A;
        row.want.tag = 8'h5A;
        rows.push_back(row);
        row.coords = {6{32'h7FFF_FFFF}};
        row.tag = 8'hA5;
        row.want.tag = 8'hA5;
        rows.push_back(row);
        foreach (rows[i]) send_item(rows[i].coords, rows[i].tag, 1'b1, rows[i].want);
        wait_drained();

        // Largest registers; a write past the list must be dropped and a wide
        // value masked.
        write_reg(CFG_TURNS_PER_MM, CFG_DATA_W'(TPM_MAX));
        write_reg(CFG_STEP_RATIO, {16'hBEEF, RATIO_MAX});
        write_reg(CFG_STEP_ENABLE, 48'hFFFF_FFFF_FFFE | 48'd1);
        write_reg(CFG_UNUSED, '1);
        rows.delete();
        row.fixed = 1'b0;
        row.want = '0;
        for (int i = 0; i < 16; i++) begin
            row.tag = 8'(i);
            case (i % 8)
                0: row.coords = {6{32'h8000_0000}};
                1: row.coords = {6{32'h7FFF_FFFF}};
                2: row.coords = {{3{32'h4000_0000}}, {3{32'sd1}}};
                3: row.coords = {32'h4000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1};
                4: row.coords = {{3{32'hC000_0000}}, {3{32'hFFFF_FFFF}}};
                5: row.coords = {32'h0, 32'h0, 32'h4000_0000, 32'h0, 32'h0, 32'd1000};
                6: row.coords = {32'h0, 32'h0, 32'h2000_0000, 32'd7, 32'h0, 32'h0};
                default: row.coords = random_coords();
            endcase
            rows.push_back(row);
            if (i == 7) begin
                rows.push_back(row);
            end
        end
        foreach (rows[i]) send_item(rows[i].coords, rows[i].tag, 1'b0, rows[i].want);
        wait_drained();
        write_reg(CFG_STEP_ENABLE, '0);
        foreach (rows[i]) send_item(rows[i].coords, rows[i].tag, 1'b0, rows[i].want);
        wait_drained();

        // Random phases with fresh registers; pairs share a stall pattern.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            if (p < 2) begin
                sender_idle_pct = 10;
                receiver_idle_pct = 83;
            end else if (p < 4) begin
                sender_idle_pct = 83;
                receiver_idle_pct = 10;
            end else begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            write_reg(CFG_TURNS_PER_MM, pick_tpm());
            write_reg(CFG_STEP_RATIO, pick_ratio());
            write_reg(CFG_STEP_ENABLE, (p % 3 == 2) ? 48'd0 : 48'd1);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                send_item(random_coords(), 8'($urandom), 1'b0, '0);
                if (p == 1 && i == PHASE_ITEMS / 2) begin
                    // Hold off until the pipeline has emptied.
                    end_burst();
                    while (phasor_fifo.size() != 0) begin
                        @(posedge i_clk);
                    end
                end
            end
            wait_drained();
        end

        $display("Sent %0d items over reset, extreme and random register settings,",
                 items_sent);
        $display("with stalls on both sides; %0d results checked.", results_seen);
        if (mismatches == 0 && phasor_fifo.size() == 0) begin
            $display("station_phase_shift_sincos_tb OK");
        end else begin
            $display("station_phase_shift_sincos_tb NOT OK");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #20_000_000;
        $display("Timed out with %0d results still expected.", phasor_fifo.size());
        $display("station_phase_shift_sincos_tb NOT OK");
        $finish;
    end

endmodule
